/* hdl/jspe_pkg.sv */
// Shared package for the Julia set pixel escape block.
// Holds widths, request/response/config structs, state and register codes.
// No dependencies; compiled first.
`default_nettype none

package jspe_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 28;

	localparam int PIX_W     = 12;
	localparam int CFG_DIM_W = 13;
	localparam int CFG_IDX_W = 8;
	localparam int ITER_W    = 16;
	localparam int IDX_W     = 24;
	localparam int SHADE_W   = 8;

	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int HDIM_W    = DIM_W - 1;
	localparam int DX_W      = ((PIX_W > HDIM_W) ? PIX_W : HDIM_W) + 1;
	localparam int NUM_W     = DX_W + 1;
	localparam int DEN_W     = 32 + $clog2(MAX_DIM);
	localparam int DIV_STEPS = NUM_W + 16 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int MUL_W     = 33;
	localparam int PROD_W    = 64;
	localparam int ESC       = 2 * FRAC_BITS + 2;
	localparam logic [PROD_W:0] ESC_LIMIT =
		(ESC < PROD_W) ? ((PROD_W + 1)'(1) << ESC) : '1;

	localparam int SUM_W =
		(((PROD_W + 1 - FRAC_BITS) > 33) ? (PROD_W + 1 - FRAC_BITS) : 33) + 1;

	localparam logic [31:0]        MAP_CAP = 32'h8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   pixel_index;
		logic [SHADE_W-1:0] shade;
		logic [ITER_W-1:0]  count_left;
	} pix_rsp_t;

	typedef struct packed {
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
		logic [31:0]        zoom;
		logic signed [31:0] off_re;
		logic signed [31:0] off_im;
		logic [ITER_W-1:0]  max_iter;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_REAL       = 8'd0,
		REG_C_IMAG       = 8'd1,
		REG_ZOOM         = 8'd2,
		REG_OFFSET_REAL  = 8'd3,
		REG_OFFSET_IMAG  = 8'd4,
		REG_MAX_ITER     = 8'd5,
		REG_IMAGE_WIDTH  = 8'd6,
		REG_IMAGE_HEIGHT = 8'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DENX,
		ST_DENY,
		ST_WAITX,
		ST_STARTY,
		ST_WAITY,
		ST_XX,
		ST_YY,
		ST_XY,
		ST_UPD,
		ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input sum_t v);
		if (v > sum_t'(S32_MAX)) begin
			return S32_MAX;
		end else if (v < sum_t'(S32_MIN)) begin
			return S32_MIN;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

/* hdl/jspe_cfg.sv */
// Configuration register file with effective-value cleanup (zoom, dims).
// Depends on jspe_pkg.
`default_nettype none

module jspe_cfg import jspe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output cfg_t                 regs
);

	logic [31:0]          c_real_q;
	logic [31:0]          c_imag_q;
	logic [31:0]          zoom_q;
	logic [31:0]          off_re_q;
	logic [31:0]          off_im_q;
	logic [ITER_W-1:0]    max_iter_q;
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end else begin
			return DIM_W'(v);
		end
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q   <= '0;
			c_imag_q   <= '0;
			zoom_q     <= 32'd65536;
			off_re_q   <= '0;
			off_im_q   <= '0;
			max_iter_q <= 16'd255;
			width_q    <= 13'd1024;
			height_q   <= 13'd768;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_C_REAL:       c_real_q   <= cfg_data;
				REG_C_IMAG:       c_imag_q   <= cfg_data;
				REG_ZOOM:         zoom_q     <= cfg_data;
				REG_OFFSET_REAL:  off_re_q   <= cfg_data;
				REG_OFFSET_IMAG:  off_im_q   <= cfg_data;
				REG_MAX_ITER:     max_iter_q <= cfg_data[ITER_W-1:0];
				REG_IMAGE_WIDTH:  width_q    <= cfg_data[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q   <= cfg_data[CFG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		regs.c_real   = c_real_q;
		regs.c_imag   = c_imag_q;
		regs.zoom     = (zoom_q == '0) ? 32'd1 : zoom_q;
		regs.off_re   = off_re_q;
		regs.off_im   = off_im_q;
		regs.max_iter = max_iter_q;
		regs.width    = clamp_dim(width_q);
		regs.height   = clamp_dim(height_q);
	end

endmodule

`default_nettype wire

/* hdl/jspe_mul.sv */
// Shared signed multiplier with registered product and load enable.
// Depends on jspe_pkg.
`default_nettype none

module jspe_mul import jspe_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);

	logic signed [2*MUL_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod[PROD_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hdl/jspe_div.sv */
// Bit-serial restoring divider for coordinate mapping, one quotient bit per cycle.
// Quotient of num * 2^(16+FRAC_BITS) / den, clamped to 2^31. Depends on jspe_pkg.
`default_nettype none

module jspe_div import jspe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [31:0]      quo
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [31:0]          q_q;
	logic                 ovf_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       trial_sub;
	logic                 fits;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});
	assign busy      = busy_q;
	assign quo       = (ovf_q || (q_q > MAP_CAP)) ? MAP_CAP : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			q_q   <= {q_q[30:0], fits};
			ovf_q <= ovf_q | q_q[31];
		end
	end

endmodule

`default_nettype wire

/* hdl/julia_set_pixel_escape.sv */
// Julia set escape-time evaluator for one pixel per request.
// Depends on jspe_pkg, jspe_cfg, jspe_mul, jspe_div.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the eight
//   view registers; cfg_ready is always high. Write only while idle.
//   req channel takes one pixel (pixel_x, pixel_y); req_ready is high only
//   while no pixel is in flight.
//   rsp channel returns pixel_index, shade and count_left from an output
//   register; a stalled response holds, and the next request may be taken
//   while it waits.
// Processing: two serial divisions of DIV_STEPS (58) quotient bits map the
//   pixel, then m loop passes run: the iteration steps taken, plus one when
//   the pixel escapes (at most max_iterations). Each pass uses the single
//   shared multiplier three times plus one update state.
// Requests: a new pixel is taken only after the previous one leaves ST_DONE.
// Reset: view registers return to their defaults, no response is pending.
`default_nettype none

module julia_set_pixel_escape import jspe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pix_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output pix_rsp_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t regs;

	state_t state_q;
	state_t state_d;

	logic [PIX_W-1:0]         px_q;
	logic [PIX_W-1:0]         py_q;
	logic [NUM_W-1:0]         num_x_q;
	logic [NUM_W-1:0]         num_y_q;
	logic                     neg_x_q;
	logic                     neg_y_q;
	logic signed [31:0]       zx_q;
	logic signed [31:0]       zy_q;
	logic [ITER_W-1:0]        it_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [PROD_W-1:0] xx_q;
	logic signed [PROD_W-1:0] diff_q;
	logic                     esc_q;
	pix_rsp_t                 rsp_q;
	logic                     rsp_valid_q;

	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] p_q;

	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic                     div_busy;
	logic [31:0]              div_quo;

	logic signed [DX_W-1:0]   dx;
	logic signed [DX_W-1:0]   dy;
	logic [DX_W-2:0]          adx;
	logic [DX_W-2:0]          ady;

	logic                     map_neg;
	logic signed [31:0]       map_off;
	sum_t                     map_sum;
	sum_t                     nx_sum;
	sum_t                     ny_sum;
	logic                     esc_d;
	logic                     rsp_free;

	jspe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	jspe_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	jspe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (p_q[DEN_W-1:0]),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// offsets from image center, magnitudes scaled by 3 (real) and 2 (imag)
	always_comb begin
		dx  = $signed(DX_W'(req.pixel_x)) - $signed(DX_W'(regs.width[DIM_W-1:1]));
		dy  = $signed(DX_W'(req.pixel_y)) - $signed(DX_W'(regs.height[DIM_W-1:1]));
		adx = (DX_W - 1)'(dx[DX_W-1] ? -dx : dx);
		ady = (DX_W - 1)'(dy[DX_W-1] ? -dy : dy);
	end

	always_comb begin
		map_neg = (state_q == ST_WAITY) ? neg_y_q : neg_x_q;
		map_off = (state_q == ST_WAITY) ? regs.off_im : regs.off_re;
		map_sum = (map_neg ? -sum_t'(div_quo) : sum_t'(div_quo)) + sum_t'(map_off);
		nx_sum  = sum_t'(diff_q >>> FRAC_BITS) + sum_t'(regs.c_real);
		ny_sum  = sum_t'(p_q >>> (FRAC_BITS - 1)) + sum_t'(regs.c_imag);
		esc_d   = (({1'b0, xx_q} + {1'b0, p_q}) >= ESC_LIMIT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_DENX;
			ST_DENX:   state_d = ST_DENY;
			ST_DENY:   state_d = ST_WAITX;
			ST_WAITX:  if (!div_busy) state_d = ST_STARTY;
			ST_STARTY: state_d = ST_WAITY;
			ST_WAITY: begin
				if (!div_busy) begin
					state_d = (it_q == '0) ? ST_DONE : ST_XX;
				end
			end
			ST_XX:     state_d = ST_YY;
			ST_YY:     state_d = ST_XY;
			ST_XY:     state_d = ST_UPD;
			ST_UPD: begin
				if (esc_q || (it_q == ITER_W'(1))) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_XX;
				end
			end
			ST_DONE:   if (rsp_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_en    = 1'b0;
		mul_a     = MUL_W'(zx_q);
		mul_b     = MUL_W'(zx_q);
		div_start = 1'b0;
		div_num   = num_x_q;
		case (state_q)
			ST_DENX: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(regs.zoom);
				mul_b  = MUL_W'(regs.width);
			end
			ST_DENY: begin
				mul_en    = 1'b1;
				mul_a     = MUL_W'(regs.zoom);
				mul_b     = MUL_W'(regs.height);
				div_start = 1'b1;
				div_num   = num_x_q;
			end
			ST_STARTY: begin
				mul_en    = 1'b1;
				mul_a     = MUL_W'(py_q);
				mul_b     = MUL_W'(regs.width);
				div_start = 1'b1;
				div_num   = num_y_q;
			end
			ST_XX: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(zx_q);
				mul_b  = MUL_W'(zx_q);
			end
			ST_YY: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(zy_q);
				mul_b  = MUL_W'(zy_q);
			end
			ST_XY: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(zx_q);
				mul_b  = MUL_W'(zy_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					px_q    <= req.pixel_x;
					py_q    <= req.pixel_y;
					num_x_q <= NUM_W'(adx) + (NUM_W'(adx) << 1);
					num_y_q <= NUM_W'(ady) << 1;
					neg_x_q <= dx[DX_W-1];
					neg_y_q <= dy[DX_W-1];
					it_q    <= regs.max_iter;
				end
			end
			ST_WAITX: begin
				if (!div_busy) begin
					zx_q <= sat32(map_sum);
				end
			end
			ST_WAITY: begin
				if (!div_busy) begin
					zy_q  <= sat32(map_sum);
					idx_q <= p_q[IDX_W-1:0] + IDX_W'(px_q);
				end
			end
			ST_YY: xx_q <= p_q;
			ST_XY: begin
				esc_q  <= esc_d;
				diff_q <= xx_q - p_q;
			end
			ST_UPD: begin
				if (!esc_q) begin
					zx_q <= sat32(nx_sum);
					zy_q <= sat32(ny_sum);
					it_q <= it_q - ITER_W'(1);
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.pixel_index <= idx_q;
					rsp_q.shade       <= SHADE_W'(0) - it_q[SHADE_W-1:0];
					rsp_q.count_left  <= it_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && !esc_q) |=> (it_q == $past(it_q) - ITER_W'(1)))
		else $error("countdown did not step on a non-escaping update");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XX || state_q == ST_UPD) |-> !div_busy)
		else $error("divider busy during iteration");

	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DENX))
		else $error("accepted request did not start mapping");

	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !rsp_valid_q) |=> rsp_valid_q)
		else $error("finished pixel not loaded into response register");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for julia_set_pixel_escape: directed and random pixels under varying view
// settings and handshake pressure, checked against an in-bench escape-time predictor.
// Depends on jspe_pkg and the julia_set_pixel_escape RTL.
module tb_top;
	import jspe_pkg::*;

	typedef struct {
		pix_req_t px;
		bit       drain;
	} pend_pixel_t;

	localparam int              PHASES      = 41;
	localparam int              PHASE_ITEMS = 30;
	localparam int              SHOW_LIMIT  = 100;
	localparam longint unsigned MAP_LIMIT   = 64'h8000_0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	pix_req_t             req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	pix_rsp_t             rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	cfg_t            view;
	pend_pixel_t     pixels_to_send[$];
	pix_rsp_t        escapes_due[$];
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int unsigned     err_count = 0;
	longint unsigned cycle_cnt = 0;
	longint unsigned cycle_limit = 50000;

	logic signed [31:0] julia_re [5] = '{-32'sd187904819, -32'sd214748365, 32'sd76504105,
		-32'sd107374182, -32'sd224143606};
	logic signed [31:0] julia_im [5] = '{32'sd72517828, 32'sd41875931, 32'sd2684355,
		32'sd161061274, -32'sd62303869};

	julia_set_pixel_escape uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned dim_used(input logic [DIM_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > MAX_DIM) begin
			return MAX_DIM;
		end
		return 64'(v);
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sh7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// k*|dx| * 2^(16+FRAC_BITS) / den, truncated and capped, then signed and offset
	function automatic logic signed [31:0] map_coord(input longint dx,
			input longint unsigned k, input longint unsigned den,
			input logic signed [31:0] off);
		longint unsigned num, quo, rem;
		int b;
		num = k * longint'((dx < 0) ? -dx : dx);
		quo = num / den;
		rem = num % den;
		if (quo > MAP_LIMIT) begin
			quo = MAP_LIMIT;
		end
		for (b = 0; b < 16 + FRAC_BITS && quo < MAP_LIMIT; b++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		if (quo > MAP_LIMIT) begin
			quo = MAP_LIMIT;
		end
		return clip32(((dx < 0) ? -longint'(quo) : longint'(quo)) + longint'(off));
	endfunction

	function automatic pix_rsp_t escape_pixel(input pix_req_t p);
		longint unsigned w, h, zm, mag;
		longint zx, zy, xx, yy, nx;
		int unsigned left;
		pix_rsp_t r;
		w  = dim_used(view.width);
		h  = dim_used(view.height);
		zm = (view.zoom == 0) ? 64'd1 : 64'(view.zoom);
		zx = map_coord(longint'(p.pixel_x) - longint'(w / 2), 3, zm * w, view.off_re);
		zy = map_coord(longint'(p.pixel_y) - longint'(h / 2), 2, zm * h, view.off_im);
		left = 32'(view.max_iter);
		while (left > 0) begin
			xx  = zx * zx;
			yy  = zy * zy;
			mag = $unsigned(xx) + $unsigned(yy);
			if (mag >= (64'd1 << (2 * FRAC_BITS + 2))) begin
				break;
			end
			nx   = clip32(((xx - yy) >>> FRAC_BITS) + longint'(view.c_real));
			zy   = clip32(((zx * zy) >>> (FRAC_BITS - 1)) + longint'(view.c_imag));
			zx   = nx;
			left = left - 1;
		end
		r.pixel_index = IDX_W'(64'(p.pixel_y) * w + 64'(p.pixel_x));
		r.shade       = SHADE_W'(32'd0 - left);
		r.count_left  = ITER_W'(left);
		return r;
	endfunction

	function automatic logic [31:0] pick_dim();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(64, 1);
			4: return 640;
			5: return 1024;
			6, 7: return $urandom_range(8191);
			8: return 0;
			default: return $urandom_range(8191, 4096);
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (err_count < SHOW_LIMIT) begin
			$display("mismatch in %s: got 0x%0h, want 0x%0h", what, got, want);
		end
		err_count++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_C_REAL:       view.c_real   = val;
			REG_C_IMAG:       view.c_imag   = val;
			REG_ZOOM:         view.zoom     = val;
			REG_OFFSET_REAL:  view.off_re   = val;
			REG_OFFSET_IMAG:  view.off_im   = val;
			REG_MAX_ITER:     view.max_iter = ITER_W'(val);
			REG_IMAGE_WIDTH:  view.width    = DIM_W'(val);
			REG_IMAGE_HEIGHT: view.height   = DIM_W'(val);
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [31:0] cre, input logic [31:0] cim,
			input logic [31:0] zm, input logic [31:0] ore, input logic [31:0] oim,
			input logic [31:0] mi, input logic [31:0] wd, input logic [31:0] ht);
		write_reg(REG_C_REAL, cre);
		write_reg(REG_C_IMAG, cim);
		write_reg(REG_ZOOM, zm);
		write_reg(REG_OFFSET_REAL, ore);
		write_reg(REG_OFFSET_IMAG, oim);
		write_reg(REG_MAX_ITER, mi);
		write_reg(REG_IMAGE_WIDTH, wd);
		write_reg(REG_IMAGE_HEIGHT, ht);
	endtask

	task automatic queue_pixel(input int x, input int y, input bit drain);
		pend_pixel_t e;
		e.px.pixel_x = PIX_W'(x);
		e.px.pixel_y = PIX_W'(y);
		e.drain      = drain;
		cycle_limit += 4 * (200 + 4 * longint'(view.max_iter));
		pixels_to_send.push_back(e);
	endtask

	// sampled mid-cycle so the clocked blocks have settled
	task automatic wait_idle();
		while (pixels_to_send.size() != 0 || req_valid || escapes_due.size() != 0)
			@(negedge clk);
	endtask

	// request driver; a drain-marked pixel waits until nothing is outstanding
	always @(posedge clk or negedge arst_n) begin
		pend_pixel_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				escapes_due.push_back(escape_pixel(req));
			end
			if (!req_valid || req_ready) begin
				if (pixels_to_send.size() > 0 &&
						!(pixels_to_send[0].drain && escapes_due.size() > 0) &&
						$urandom_range(99) >= send_idle_pct) begin
					nxt = pixels_to_send.pop_front();
					req_valid <= 1'b1;
					req       <= nxt.px;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pix_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (escapes_due.size() == 0) begin
					flag_mismatch("unrequested response", rsp.pixel_index, 0);
				end else begin
					want = escapes_due.pop_front();
					if (rsp.pixel_index !== want.pixel_index) begin
						flag_mismatch("pixel_index", rsp.pixel_index, want.pixel_index);
					end
					if (rsp.shade !== want.shade) begin
						flag_mismatch("shade", rsp.shade, want.shade);
					end
					if (rsp.count_left !== want.count_left) begin
						flag_mismatch("count_left", rsp.count_left, want.count_left);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > cycle_limit) begin
			$display("julia_set_pixel_escape verification failed");
			$finish;
		end
	end

	initial begin
		int ph, n, k, sel, x, y;
		logic [31:0] cre, cim, zm, ore, oim, mi;
		view = '{c_real: '0, c_imag: '0, zoom: 65536, off_re: '0, off_im: '0,
			max_iter: 255, width: 1024, height: 768};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default view: center point never escapes, plus corners
		queue_pixel(512, 384, 1'b0);
		queue_pixel(0, 0, 1'b0);
		queue_pixel(4095, 4095, 1'b0);
		queue_pixel(4095, 0, 1'b0);
		queue_pixel(0, 4095, 1'b0);
		queue_pixel(511, 383, 1'b0);
		wait_idle();

		// zero zoom, zero sizes, zero iteration limit, extreme constants and offsets
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0, 32'h0, 32'h0);
		queue_pixel(4095, 4095, 1'b0);
		queue_pixel(0, 0, 1'b0);
		wait_idle();
		write_reg(REG_MAX_ITER, 32'd3);
		queue_pixel(4095, 0, 1'b0);
		queue_pixel(0, 4095, 1'b0);
		wait_idle();

		// oversize dimensions clamp, finest zoom, opposite extremes
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd5, 32'd8191, 32'd8191);
		queue_pixel(4095, 4095, 1'b0);
		queue_pixel(0, 0, 1'b0);
		queue_pixel(2048, 2048, 1'b0);
		wait_idle();

		// longest countdown: origin with zero constant stays put
		set_view(32'h0, 32'h0, 32'd65536, 32'h0, 32'h0, 32'd65535, 32'd4096, 32'd4096);
		queue_pixel(2048, 2048, 1'b0);
		queue_pixel(0, 0, 1'b0);
		wait_idle();

		set_view(julia_re[0], julia_im[0], 32'd65536, 32'h0, 32'h0, 32'd200, 32'd64, 32'd48);
		queue_pixel(32, 24, 1'b0);
		queue_pixel(10, 20, 1'b0);
		queue_pixel(40, 30, 1'b0);
		queue_pixel(63, 47, 1'b0);
		queue_pixel(0, 24, 1'b0);
		wait_idle();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_idle_pct  = 38;
					recv_stall_pct = 38;
				end
			endcase

			sel = $urandom_range(9);
			k   = $urandom_range(4);
			if (sel < 6) begin
				cre = julia_re[k] + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
				cim = julia_im[k] + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
			end else if (sel < 8) begin
				cre = $urandom;
				cim = $urandom;
			end else begin
				cre = $urandom_range(32'h4000_0000) - 32'h2000_0000;
				cim = $urandom_range(32'h4000_0000) - 32'h2000_0000;
			end

			case ($urandom_range(9))
				0: zm = 32'h0;
				1: zm = 32'hFFFF_FFFF;
				2: zm = $urandom_range(16, 1);
				3, 4: zm = $urandom;
				default: zm = $urandom_range(32'h0004_0000, 32'h0000_4000);
			endcase

			sel = $urandom_range(9);
			if (sel < 6) begin
				ore = $urandom_range(32'h1000_0000) - 32'h0800_0000;
				oim = $urandom_range(32'h1000_0000) - 32'h0800_0000;
			end else if (sel < 8) begin
				ore = $urandom;
				oim = $urandom;
			end else begin
				ore = 32'h0;
				oim = 32'h0;
			end

			sel = $urandom_range(19);
			if (sel < 2) begin
				mi = 32'd0;
			end else if (sel == 2) begin
				mi = $urandom_range(255, 100);
			end else begin
				mi = $urandom_range(48, 1);
			end

			set_view(cre, cim, zm, ore, oim, mi, pick_dim(), pick_dim());

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(9) < 7) begin
					x = $urandom_range(32'(dim_used(view.width) - 1));
					y = $urandom_range(32'(dim_used(view.height) - 1));
				end else begin
					x = $urandom_range((1 << PIX_W) - 1);
					y = $urandom_range((1 << PIX_W) - 1);
				end
				queue_pixel(x, y, (n == 5) || ($urandom_range(99) < 3));
			end
			wait_idle();
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (err_count == 0) begin
			$display("julia_set_pixel_escape verification clean");
		end else begin
			$display("julia_set_pixel_escape verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/jspe_pkg.sv
hdl/jspe_cfg.sv
hdl/jspe_mul.sv
hdl/jspe_div.sv
hdl/julia_set_pixel_escape.sv
tb/tb_top.sv
